### rtl/fps_pkg.sv
// fps_pkg: shared constants and types for the fading point store
// no dependencies
package fps_pkg;
   localparam int DEPTH = 64;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int ENTRY_W = 16 + 16 + 32 + 1;
   localparam int ADDR_W = 3;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_EXPIRE = 2'd1,
      OP_QUERY = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   localparam logic [ADDR_W-1:0] REG_LIFETIME = 3'd0;
   localparam logic [ADDR_W-1:0] REG_FADE_START = 3'd4;

   localparam logic [31:0] LIFETIME_RESET = 32'd5000;
   localparam logic [31:0] FADE_START_RESET = 32'd3000;
   localparam logic [8:0] WEIGHT_FULL = 9'd256;

   typedef struct packed {
      logic        good;
      logic [15:0] angle;
      logic [15:0] distance;
      logic [31:0] stamp;
   } entry_type;
endpackage

### rtl/fading_point_store_top.sv
// fading_point_store_top: ordered point store with linear fade weight
// uses fps_pkg and fps_ram
//
// Points sit in one ring memory with a head pointer and fill count. Add and
// clear finish in the idle state. Expire and query walk the stored entries one
// at a time (memory read, then evaluate); expire compacts in place. A query hit
// that needs fading runs a restoring divider, and a hit is held back until the
// next hit or the end of the scan shows whether it is the last one. The input
// is stalled until the current item has finished.
module fading_point_store_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_operation,
   input  logic [31:0]                 req_time_now,
   input  logic [15:0]                 req_point_angle,
   input  logic [15:0]                 req_point_distance,
   input  logic                        req_point_good,
   input  logic [15:0]                 req_min_angle,
   input  logic [15:0]                 req_max_angle,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_hit,
   output logic [15:0]                 rsp_angle_out,
   output logic [15:0]                 rsp_distance_out,
   output logic [31:0]                 rsp_stamp_out,
   output logic [8:0]                  rsp_weight,
   output logic                        rsp_last,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [fps_pkg::ADDR_W-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import fps_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_EVAL, S_DIV, S_EMIT, S_DONE
   } state_type;

   state_type state_ff;
   logic [31:0] lifetime_ff, fade_start_ff;
   logic [IDX_W-1:0] head_ff;
   logic [CNT_W-1:0] fill_ff;
   logic [CNT_W-1:0] scan_ff;   // read position
   logic [CNT_W-1:0] keep_ff;   // compaction write position
   op_type op_ff;
   logic [31:0] now_ff;
   logic [15:0] lo_ff, hi_ff;
   logic have_ff;             // a finished hit is held back
   logic [32:0] rem_ff;
   logic [31:0] den_ff;
   logic [8:0] quo_ff;
   logic [3:0] div_cnt_ff;
   entry_type held_ff;
   logic pend_ff;             // held hit takes its weight from the divider
   logic [8:0] held_w_ff;

   logic rsp_valid_ff, rsp_hit_ff, rsp_last_ff;
   logic [15:0] rsp_angle_ff, rsp_dist_ff;
   logic [31:0] rsp_stamp_ff;
   logic [8:0] rsp_weight_ff;

   logic wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   entry_type wr_data, rd_data;
   logic [ENTRY_W-1:0] rd_raw;

   fps_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_raw)
   );
   assign rd_data = entry_type'(rd_raw);

   function automatic logic [IDX_W-1:0] ring(input logic [IDX_W-1:0] h,
                                             input logic [CNT_W-1:0] o);
      logic [CNT_W:0] s;
      s = {1'b0, {(CNT_W - IDX_W){1'b0}}, h} + {1'b0, o};
      if (s >= (CNT_W+1)'(DEPTH)) s = s - (CNT_W+1)'(DEPTH);
      return s[IDX_W-1:0];
   endfunction

   assign pready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   logic req_take;
   assign req_take = req_valid && !req_stall;
   logic out_free;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   logic rsp_load;
   assign rsp_load = out_free && (state_ff == S_EMIT || state_ff == S_DONE);

   // evaluation of the entry just read
   logic [31:0] age, eval_f, eval_d;
   logic future, gone, match;
   assign future = now_ff < rd_data.stamp;
   assign age = now_ff - rd_data.stamp;
   assign gone = !future && (age >= lifetime_ff);
   assign match = rd_data.good && (rd_data.angle >= lo_ff) && (rd_data.angle <= hi_ff);
   assign eval_f = age - fade_start_ff;
   assign eval_d = lifetime_ff - fade_start_ff;
   logic scan_more;
   assign scan_more = (scan_ff + 1'b1) < fill_ff;

   assign rd_addr = ring(head_ff, scan_ff);
   always_comb begin
      wr_en = 1'b0;
      wr_addr = ring(head_ff, fill_ff);
      wr_data = entry_type'({req_point_good, req_point_angle, req_point_distance,
                             req_time_now});
      if (state_ff == S_IDLE && req_take &&
          op_type'(req_operation) == OP_ADD) begin
         wr_en = 1'b1;
         if (fill_ff == CNT_W'(DEPTH)) wr_addr = head_ff;
      end else if (state_ff == S_EVAL && op_ff == OP_EXPIRE && !gone) begin
         wr_en = 1'b1;
         wr_addr = ring(head_ff, keep_ff);
         wr_data = rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         lifetime_ff <= LIFETIME_RESET;
         fade_start_ff <= FADE_START_RESET;
         head_ff <= '0;
         fill_ff <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff <= 1'b0;
         have_ff <= 1'b0;
      end else begin
         if (psel && penable && pwrite) begin
            if (paddr == REG_LIFETIME) lifetime_ff <= pwdata;
            else if (paddr == REG_FADE_START) fade_start_ff <= pwdata;
         end
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  op_ff <= op_type'(req_operation);
                  now_ff <= req_time_now;
                  lo_ff <= req_min_angle;
                  hi_ff <= req_max_angle;
                  scan_ff <= '0;
                  keep_ff <= '0;
                  have_ff <= 1'b0;
                  pend_ff <= 1'b0;
                  unique case (op_type'(req_operation))
                     OP_ADD: begin
                        if (fill_ff == CNT_W'(DEPTH)) head_ff <= ring(head_ff, CNT_W'(1));
                        else fill_ff <= fill_ff + 1'b1;
                     end
                     OP_CLEAR: fill_ff <= '0;
                     OP_EXPIRE: begin
                        if (fill_ff != '0) state_ff <= S_READ;
                     end
                     OP_QUERY: state_ff <= (fill_ff == '0) ? S_DONE : S_READ;
                  endcase
               end
            end
            S_READ: state_ff <= S_EVAL;
            S_EVAL: begin
               if (op_ff == OP_EXPIRE) begin
                  if (!gone) keep_ff <= keep_ff + 1'b1;
                  scan_ff <= scan_ff + 1'b1;
                  if (scan_more) state_ff <= S_READ;
                  else begin
                     fill_ff <= keep_ff + CNT_W'(!gone);
                     state_ff <= S_IDLE;
                  end
               end else if (match && have_ff) begin
                  // the earlier hit is not the last; send it, then look again
                  state_ff <= S_EMIT;
               end else if (match) begin
                  held_ff <= rd_data;
                  if (!future && age >= fade_start_ff && age < lifetime_ff &&
                      eval_d != '0) begin
                     // 256*(d-f)/d, one quotient bit per cycle
                     rem_ff <= {1'b0, eval_d - eval_f};
                     den_ff <= eval_d;
                     quo_ff <= '0;
                     div_cnt_ff <= '0;
                     state_ff <= S_DIV;
                  end else begin
                     held_w_ff <= (!future && age < fade_start_ff) ? WEIGHT_FULL : '0;
                     have_ff <= 1'b1;
                     pend_ff <= 1'b0;
                     scan_ff <= scan_ff + 1'b1;
                     state_ff <= scan_more ? S_READ : S_DONE;
                  end
               end else begin
                  scan_ff <= scan_ff + 1'b1;
                  state_ff <= scan_more ? S_READ : S_DONE;
               end
            end
            S_DIV: begin
               // remainder r <= d, quotient of r*2^8/d built msb first
               if (div_cnt_ff == 4'd0) begin
                  // leading bit: (d-f)/d, which is 1 only if f==0
                  if (rem_ff[31:0] >= den_ff) begin
                     quo_ff <= 9'd1; rem_ff <= {1'b0, rem_ff[31:0] - den_ff};
                  end
               end else begin
                  if ({rem_ff[31:0], 1'b0} >= {1'b0, den_ff}) begin
                     rem_ff <= {rem_ff[31:0], 1'b0} - {1'b0, den_ff};
                     quo_ff <= {quo_ff[7:0], 1'b1};
                  end else begin
                     rem_ff <= {rem_ff[31:0], 1'b0};
                     quo_ff <= {quo_ff[7:0], 1'b0};
                  end
               end
               div_cnt_ff <= div_cnt_ff + 1'b1;
               if (div_cnt_ff == 4'd8) begin
                  pend_ff <= 1'b1;
                  have_ff <= 1'b1;
                  scan_ff <= scan_ff + 1'b1;
                  state_ff <= scan_more ? S_READ : S_DONE;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_hit_ff <= 1'b1;
                  rsp_angle_ff <= held_ff.angle;
                  rsp_dist_ff <= held_ff.distance;
                  rsp_stamp_ff <= held_ff.stamp;
                  rsp_weight_ff <= pend_ff ? quo_ff : held_w_ff;
                  rsp_last_ff <= 1'b0;
                  pend_ff <= 1'b0;
                  have_ff <= 1'b0;
                  state_ff <= S_EVAL;
               end
            end
            S_DONE: begin
               // close the query: send the held hit as last, or an empty result
               if (out_free) begin
                  if (have_ff) begin
                     rsp_hit_ff <= 1'b1;
                     rsp_angle_ff <= held_ff.angle;
                     rsp_dist_ff <= held_ff.distance;
                     rsp_stamp_ff <= held_ff.stamp;
                     rsp_weight_ff <= pend_ff ? quo_ff : held_w_ff;
                  end else begin
                     rsp_hit_ff <= 1'b0;
                     rsp_angle_ff <= '0;
                     rsp_dist_ff <= '0;
                     rsp_stamp_ff <= '0;
                     rsp_weight_ff <= '0;
                  end
                  rsp_last_ff <= 1'b1;
                  pend_ff <= 1'b0;
                  have_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit = rsp_hit_ff;
   assign rsp_angle_out = rsp_angle_ff;
   assign rsp_distance_out = rsp_dist_ff;
   assign rsp_stamp_out = rsp_stamp_ff;
   assign rsp_weight = rsp_weight_ff;
   assign rsp_last = rsp_last_ff;

   always_comb begin
      prdata = '0;
      if (paddr == REG_LIFETIME) prdata = lifetime_ff;
      else if (paddr == REG_FADE_START) prdata = fade_start_ff;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(DEPTH)) else $error("fill count above depth");
   a_weight_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_weight <= WEIGHT_FULL) else $error("weight above full");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> req_stall) else $error("input taken while busy");
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_last) else $error("empty result not last");
endmodule

### rtl/fps_ram.sv
// fps_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
module fps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### tb/testbench.sv
// testbench: self-checking regression for fading_point_store_top
// depends on fps_pkg and the fading_point_store_top rtl
`timescale 1ns / 1ps

module testbench;
   import fps_pkg::*;

   typedef struct {
      op_type      op;
      logic [31:0] now;
      logic [15:0] angle;
      logic [15:0] distance;
      logic        good;
      logic [15:0] lo;
      logic [15:0] hi;
   } point_op_type;

   typedef struct {
      logic        hit;
      logic [15:0] angle;
      logic [15:0] distance;
      logic [31:0] stamp;
      logic [8:0]  weight;
      logic        last;
   } point_hit_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_operation = 0;
   logic [31:0] req_time_now = 0;
   logic [15:0] req_point_angle = 0, req_point_distance = 0;
   logic req_point_good = 0;
   logic [15:0] req_min_angle = 0, req_max_angle = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic rsp_hit, rsp_last;
   logic [15:0] rsp_angle_out, rsp_distance_out;
   logic [31:0] rsp_stamp_out;
   logic [8:0] rsp_weight;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [ADDR_W-1:0] paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic pready;

   fading_point_store_top u_dut (.*);

   always #2 clock = ~clock;

   // model of the store
   logic [31:0] life_ms, fade_ms;
   logic [15:0] st_angle[DEPTH];
   logic [15:0] st_dist[DEPTH];
   logic [31:0] st_stamp[DEPTH];
   logic        st_good[DEPTH];
   int          st_count;

   point_op_type  pending_ops[$];
   point_hit_type expected_hits[$];
   int  errors = 0, queries = 0, hits_seen = 0, cycles = 0;
   int  send_idle_pct = 0, recv_stall_pct = 0, hold_off = 0;

   // a transfer on the input seen at the last rising edge
   logic accepted_last = 0;

   task automatic queue_op(point_op_type t);
      pending_ops.insert(pending_ops.size(), t);
   endtask

   task automatic expect_result(point_hit_type r);
      expected_hits.insert(expected_hits.size(), r);
   endtask

   function automatic logic [8:0] fade_weight(int i, logic [31:0] now);
      logic [31:0] age, f, d;
      if (!st_good[i] || now < st_stamp[i]) return 9'd0;
      age = now - st_stamp[i];
      if (age < fade_ms) return WEIGHT_FULL;
      if (age >= life_ms) return 9'd0;
      f = age - fade_ms;
      d = life_ms - fade_ms;
      return 9'((64'd256 * (d - f)) / d);
   endfunction

   task automatic predict_op(point_op_type t);
      int n;
      point_hit_type r;
      case (t.op)
         OP_ADD: begin
            if (st_count >= DEPTH) begin
               for (int i = 1; i < DEPTH; i++) begin
                  st_angle[i-1] = st_angle[i]; st_dist[i-1] = st_dist[i];
                  st_stamp[i-1] = st_stamp[i]; st_good[i-1] = st_good[i];
               end
               st_count = DEPTH - 1;
            end
            st_angle[st_count] = t.angle; st_dist[st_count] = t.distance;
            st_stamp[st_count] = t.now; st_good[st_count] = t.good;
            st_count++;
         end
         OP_EXPIRE: begin
            n = 0;
            for (int i = 0; i < st_count; i++)
               if (!(t.now >= st_stamp[i] && t.now - st_stamp[i] >= life_ms)) begin
                  st_angle[n] = st_angle[i]; st_dist[n] = st_dist[i];
                  st_stamp[n] = st_stamp[i]; st_good[n] = st_good[i];
                  n++;
               end
            st_count = n;
         end
         OP_CLEAR: st_count = 0;
         default: begin
            n = 0;
            for (int i = 0; i < st_count; i++)
               if (st_good[i] && st_angle[i] >= t.lo && st_angle[i] <= t.hi) begin
                  r = '{1'b1, st_angle[i], st_dist[i], st_stamp[i],
                        fade_weight(i, t.now), 1'b0};
                  expect_result(r);
                  n++;
               end
            if (n == 0) begin
               r = '{1'b0, 16'd0, 16'd0, 32'd0, 9'd0, 1'b1};
               expect_result(r);
            end else
               expected_hits[$].last = 1;
         end
      endcase
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // driver
   always @(negedge clock) begin
      point_op_type t;
      if (!reset) begin
         if (!req_valid || accepted_last) begin
            if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               t = pending_ops.pop_front();
               predict_op(t);
               req_valid <= 1;
               req_operation <= t.op; req_time_now <= t.now;
               req_point_angle <= t.angle; req_point_distance <= t.distance;
               req_point_good <= t.good;
               req_min_angle <= t.lo; req_max_angle <= t.hi;
            end else
               req_valid <= 0;
         end
         if (hold_off > 0) rsp_stall <= 1;
         else rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      accepted_last <= req_valid && !req_stall;
      cycles <= cycles + 1;
   end

   // long receiver hold-off, counted on its own
   always @(posedge clock) if (hold_off > 0) hold_off <= hold_off - 1;

   // monitor
   always @(posedge clock) begin
      point_hit_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         hits_seen++;
         if (expected_hits.size() == 0) begin
            report_mismatch("unexpected transfer", 32'(rsp_hit), 32'd0);
         end else begin
            e = expected_hits.pop_front();
            if (rsp_hit !== e.hit) report_mismatch("hit", 32'(rsp_hit), 32'(e.hit));
            if (rsp_angle_out !== e.angle)
               report_mismatch("angle", 32'(rsp_angle_out), 32'(e.angle));
            if (rsp_distance_out !== e.distance)
               report_mismatch("distance", 32'(rsp_distance_out), 32'(e.distance));
            if (rsp_stamp_out !== e.stamp) report_mismatch("stamp", rsp_stamp_out, e.stamp);
            if (rsp_weight !== e.weight)
               report_mismatch("weight", 32'(rsp_weight), 32'(e.weight));
            if (rsp_last !== e.last) report_mismatch("last", 32'(rsp_last), 32'(e.last));
         end
      end
   end

   always @(posedge clock)
      if (cycles > 2000000) begin
         $display("timeout");
         $display("fading_point_store_top regression: fail");
         $finish;
      end

   task automatic csr_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
      @(negedge clock);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
      @(negedge clock);
      penable <= 1;
      @(negedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      if (addr == REG_LIFETIME) life_ms = data; else fade_ms = data;
   endtask

   task automatic drain;
      while (pending_ops.size() > 0 || req_valid || expected_hits.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic point_op_type make_op(op_type op, logic [31:0] now,
                                            logic [15:0] a, logic [15:0] lo,
                                            logic [15:0] hi);
      point_op_type t;
      t.op = op; t.now = now; t.angle = a; t.distance = 16'($urandom);
      t.good = 1; t.lo = lo; t.hi = hi;
      return t;
   endfunction

   // random phase: mostly adds and queries near a moving clock
   task automatic random_ops(int count, logic [31:0] span);
      point_op_type t;
      logic [31:0] base;
      base = $urandom;
      for (int k = 0; k < count; k++) begin
         t = make_op(op_type'(2'($urandom)), base + $urandom_range(span), 16'($urandom),
                     16'($urandom), 16'($urandom));
         case ($urandom_range(9))
            0, 1, 2, 3: t.op = OP_ADD;
            4, 5, 6: begin
               t.op = OP_QUERY;
               if ($urandom_range(3) != 0) begin
                  t.lo = 16'($urandom_range(32767)); t.hi = t.lo + 16'($urandom_range(32768));
               end
            end
            7: t.op = OP_EXPIRE;
            8: if ($urandom_range(3) != 0) t.op = OP_ADD;
            default: ;
         endcase
         t.good = $urandom_range(4) != 0;
         if (t.op == OP_ADD) base += $urandom_range(span / 8);
         queue_op(t);
      end
   endtask

   initial begin
      life_ms = LIFETIME_RESET; fade_ms = FADE_START_RESET; st_count = 0;
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 0;

      // directed: extremes, every operation, empty and inverted ranges
      queue_op(make_op(OP_QUERY, 0, 0, 0, 16'hffff));
      queue_op(make_op(OP_ADD, 1000, 0, 0, 0));
      queue_op(make_op(OP_ADD, 32'hffffffff, 16'hffff, 0, 0));
      queue_op(make_op(OP_ADD, 2000, 100, 0, 0));
      pending_ops[$].good = 0;
      pending_ops[$].distance = 16'hffff;
      queue_op(make_op(OP_ADD, 0, 100, 0, 0));
      pending_ops[$].distance = 0;
      queue_op(make_op(OP_QUERY, 1500, 0, 0, 16'hffff));
      queue_op(make_op(OP_QUERY, 5000, 0, 0, 16'hffff));
      queue_op(make_op(OP_QUERY, 4500, 0, 200, 100));
      queue_op(make_op(OP_QUERY, 4500, 0, 100, 100));
      queue_op(make_op(OP_QUERY, 4500, 0, 16'hffff, 16'hffff));
      queue_op(make_op(OP_QUERY, 6000, 0, 0, 16'hffff));
      queue_op(make_op(OP_EXPIRE, 5000, 0, 0, 0));
      queue_op(make_op(OP_QUERY, 5000, 0, 0, 16'hffff));
      queue_op(make_op(OP_CLEAR, 0, 0, 0, 0));
      queue_op(make_op(OP_QUERY, 5000, 0, 0, 16'hffff));
      // overfill to force the oldest point out
      for (int k = 0; k < DEPTH + 3; k++)
         queue_op(make_op(OP_ADD, 32'(10 * k), 16'(k), 0, 0));
      queue_op(make_op(OP_QUERY, 3500, 0, 0, 16'hffff));
      drain();

      // fading window inverted and extreme register values
      csr_write(REG_LIFETIME, 32'd1000); csr_write(REG_FADE_START, 32'd2000);
      random_ops(40, 4000);
      drain();
      csr_write(REG_LIFETIME, 32'hffffffff); csr_write(REG_FADE_START, 32'd0);
      send_idle_pct = 66;
      random_ops(50, 32'hffffffff);
      drain();
      csr_write(REG_LIFETIME, 32'd0); csr_write(REG_FADE_START, 32'hffffffff);
      send_idle_pct = 0; recv_stall_pct = 66;
      random_ops(40, 1000);
      drain();
      csr_write(REG_LIFETIME, 32'd700); csr_write(REG_FADE_START, 32'd100);
      send_idle_pct = 16; recv_stall_pct = 16;
      random_ops(40, 1500);
      drain();

      // receiver holds off while queries pile up
      csr_write(REG_LIFETIME, LIFETIME_RESET); csr_write(REG_FADE_START, FADE_START_RESET);
      send_idle_pct = 0; recv_stall_pct = 0;
      @(negedge clock) hold_off = 3000;
      random_ops(70, 6000);
      drain();

      $display("ran %0d cycles, %0d query results checked over several fade settings",
               cycles, hits_seen);
      if (errors == 0)
         $display("fading_point_store_top regression: pass");
      else
         $display("fading_point_store_top regression: fail");
      $finish;
   end
endmodule
